/* sv/assert_macros.svh */
// assertion macros shared by the console rtl
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/tcw_pkg.sv */
// types, codes and constants of the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 11;
   localparam int LOC_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LOC_W-1:0]  loc_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ATTR_W-1:0] attr_type;

   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_CLEAR = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   localparam byte_type CH_BS    = 8'h08;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_LAST  = 8'h7F;

   localparam attr_type RESET_ATTR = 8'h07;

   function automatic cell_type blank_cell(input attr_type attr);
      return {attr, CH_SPACE};
   endfunction

endpackage

/* sv/tcw_channels.sv */
// valid/ready channel interfaces for the request and response sides
// depends on tcw_pkg
`timescale 1ns / 1ps

interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   byte_type char_byte;
   idx_type  cell_index;

   modport source (output valid, output cmd, output char_byte, output cell_index,
                   input ready);
   modport sink   (input valid, input cmd, input char_byte, input cell_index,
                   output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic     valid;
   logic     ready;
   loc_type  cursor_pos;
   cell_type cell_data;

   modport source (output valid, output cursor_pos, output cell_data,
                   input ready);
   modport sink   (input valid, input cursor_pos, input cell_data,
                   output ready);
endinterface

/* sv/text_console_writer_core.sv */
// text console writer: cursor tracking and screen store sequencer
// depends on tcw_pkg, tcw_channels, tcw_ram and assert_macros.svh
//
//  req_ch carries one command per transfer: write a byte, clear the screen,
//  or read one cell. rsp_ch returns exactly one transfer per command with the
//  cursor location after the command and, for a read, the cell contents.
//  csr_we/csr_wdata set the attribute byte used for stored and blank cells.
//  one command at a time: req_ch.ready is high only in idle, so a new
//  command is taken only once the response to the last one is registered.
//  every cell of a clear or scroll is written through the screen ram's single
//  write port; a scroll copy reads one row ahead through the registered port.
//  after reset the screen ram is swept to blanks with attribute 7 while
//  req_ch.ready is low; csr writes are taken meanwhile.
//  a stalled response is held in the output register; the next request is
//  still taken and its result waits until the output register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic          clock,
   input  logic          reset,
   tcw_req_if.sink       req_ch,
   tcw_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  attr_type      csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CMP_W  = (ADDR_W > IDX_W ? ADDR_W : IDX_W) + 1;

   localparam logic [COL_W:0]    COLS_X    = (COL_W+1)'(COLUMNS);
   localparam logic [ROW_W:0]    ROWS_X    = (ROW_W+1)'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [CMP_W-1:0]  CELLS_C   = CMP_W'(CELLS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_COPY = 3'd2;
   localparam logic [2:0] S_FILL = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]        state_ff,    state_in;
   logic [COL_W-1:0]  col_ff,      col_in;
   logic [ROW_W-1:0]  row_ff,      row_in;
   attr_type          attr_ff,     attr_in;
   logic              init_ff,     init_in;
   logic [ADDR_W-1:0] ptr_ff,      ptr_in;
   logic              copy_wr_ff,  copy_wr_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   cell_type          data_ff,     data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   loc_type           rsp_loc_ff,  rsp_loc_in;
   cell_type          rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   cell_type          ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   cell_type          ram_rdata;

   logic [ADDR_W-1:0] cur_addr;
   logic [COL_W:0]    col_ext;
   logic [COL_W:0]    col_x;
   logic [COL_W:0]    tab_sum;
   logic [ROW_W:0]    row_x;
   logic              row_inc;
   logic              do_store;
   logic              wrap;
   logic              scroll;
   logic [CMP_W-1:0]  idx_wide;
   logic              idx_ok;
   logic              xfer_in;
   logic              out_free;
   logic              copy_busy;

   tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cur_addr  = ADDR_W'(row_ff * COLS_A) + ADDR_W'(col_ff);
   assign col_ext   = {1'b0, col_ff};
   assign tab_sum   = col_ext + (COL_W+1)'(8);
   assign idx_wide  = CMP_W'(req_ch.cell_index);
   assign idx_ok    = idx_wide < CELLS_C;
   assign xfer_in   = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign copy_busy = (state_ff == S_COPY) || (state_ff == S_FILL);

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_pos = rsp_loc_ff;
   assign rsp_ch.cell_data  = rsp_data_ff;

   // byte interpretation for a write command
   always_comb begin
      col_x    = col_ext;
      row_inc  = 1'b0;
      do_store = 1'b0;
      case (req_ch.char_byte)
         CH_BS: begin
            if (col_ff != '0) begin
               col_x = col_ext - (COL_W+1)'(1);
            end
         end
         CH_TAB: begin
            col_x = {tab_sum[COL_W:3], 3'b000};
         end
         CH_CR: begin
            col_x = '0;
         end
         CH_LF: begin
            col_x   = '0;
            row_inc = 1'b1;
         end
         default: begin
            if (req_ch.char_byte >= CH_SPACE && req_ch.char_byte <= CH_LAST) begin
               do_store = 1'b1;
               col_x    = col_ext + (COL_W+1)'(1);
            end
         end
      endcase
      wrap = (col_x >= COLS_X);
      if (wrap) begin
         col_x   = '0;
         row_inc = 1'b1;
      end
      row_x  = {1'b0, row_ff} + (ROW_W+1)'(row_inc);
      scroll = (row_x >= ROWS_X);
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = csr_we ? csr_wdata : attr_ff;
      init_in      = init_ff;
      ptr_in       = ptr_ff;
      copy_wr_in   = 1'b0;
      copy_addr_in = copy_addr_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_loc_in   = rsp_loc_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = blank_cell(init_ff ? RESET_ATTR : attr_ff);
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff + COLS_A;

      // pending scroll copy owns the write port
      if (copy_wr_ff) begin
         ram_we    = 1'b1;
         ram_waddr = copy_addr_ff;
         ram_wdata = ram_rdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (xfer_in) begin
               data_in = '0;
               case (req_ch.cmd)
                  CMD_WRITE: begin
                     if (do_store) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr_ff, req_ch.char_byte};
                     end
                     col_in = col_x[COL_W-1:0];
                     if (scroll) begin
                        row_in   = ROW_LAST;
                        ptr_in   = '0;
                        state_in = S_COPY;
                     end else begin
                        row_in   = row_x[ROW_W-1:0];
                        state_in = S_DONE;
                     end
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     state_in = S_FILL;
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_wide[ADDR_W-1:0];
                        state_in  = S_READ;
                     end else begin
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            data_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_COPY: begin
            ram_re       = 1'b1;
            copy_wr_in   = 1'b1;
            copy_addr_in = ptr_ff;
            if (ptr_ff == COPY_LAST) begin
               ptr_in   = BOTTOM;
               state_in = S_FILL;
            end else begin
               ptr_in   = ptr_ff + ADDR_W'(1);
            end
         end
         S_FILL: begin
            if (!copy_wr_ff) begin
               ram_we = 1'b1;
               if (ptr_ff == CELL_LAST) begin
                  init_in  = 1'b0;
                  state_in = init_ff ? S_IDLE : S_DONE;
               end else begin
                  ptr_in   = ptr_ff + ADDR_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_loc_in   = loc_type'(cur_addr);
               rsp_data_in  = data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         init_ff      <= 1'b1;
         ptr_ff       <= '0;
         copy_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         init_ff      <= init_in;
         ptr_ff       <= ptr_in;
         copy_wr_ff   <= copy_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      data_ff      <= data_in;
      rsp_loc_ff   <= rsp_loc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `ASSERT_IMPLY(a_col_range, 1'b1, col_ext < COLS_X, "cursor column past last column")
   `ASSERT_IMPLY(a_row_range, 1'b1, {1'b0, row_ff} < ROWS_X, "cursor row past last row")
   `ASSERT_IMPLY(a_copy_wr_state, copy_wr_ff, copy_busy, "copy write outside scroll")
   `ASSERT_NEXT(a_busy_after_xfer, xfer_in, state_ff != S_IDLE, "idle after request transfer")

endmodule

/* sv/tcw_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/testbench.sv */
// self-checking testbench for text_console_writer_core: a console predictor
// follows every request transfer and the response monitor checks each result
// depends on tcw_pkg, tcw_channels and the core rtl
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int TAB_STOP     = 8;
   localparam int IDX_MAX      = (1 << IDX_W) - 1;
   localparam cmd_type CMD_SPARE = 2'd3;

   typedef struct packed {
      cmd_type  cmd;
      byte_type char_byte;
      idx_type  cell_index;
   } console_req_type;

   typedef struct packed {
      loc_type  cursor_pos;
      cell_type cell_data;
   } console_rsp_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_we;
   attr_type csr_wdata;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_core #(
      .COLUMNS (SCREEN_COLS),
      .ROWS    (SCREEN_ROWS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // console state as the predictor sees it
   cell_type screen_model [SCREEN_CELLS];
   int       cur_col;
   int       cur_row;
   attr_type attr_model;

   console_req_type pending_req [$];
   console_rsp_type expected_rsp [$];
   console_req_type next_req;
   console_rsp_type got_rsp;
   int           outstanding = 0;
   int           phase_count = 0;
   int           errors = 0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   bit           idle_off = 1'b0;

   function automatic console_rsp_type console_step(input console_req_type it);
      console_rsp_type r;
      cell_type     blank;
      int           c;
      int           i;
      r.cell_data = '0;
      blank = {attr_model, CH_SPACE};
      case (it.cmd)
         CMD_WRITE: begin
            c = cur_col;
            if (it.char_byte == CH_BS) begin
               if (c > 0) c--;
            end else if (it.char_byte == CH_TAB) begin
               c = (c + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (it.char_byte == CH_CR) begin
               c = 0;
            end else if (it.char_byte == CH_LF) begin
               c = 0;
               cur_row++;
            end else if (it.char_byte >= CH_SPACE && it.char_byte <= CH_LAST) begin
               if (cur_row * SCREEN_COLS + c < SCREEN_CELLS)
                  screen_model[cur_row * SCREEN_COLS + c] = {attr_model, it.char_byte};
               c++;
            end
            if (c >= SCREEN_COLS) begin
               c = 0;
               cur_row++;
            end
            cur_col = c;
            // scroll up one row and blank the bottom row
            if (cur_row >= SCREEN_ROWS) begin
               for (i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
                  screen_model[i] = screen_model[i + SCREEN_COLS];
               for (i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
                  screen_model[i] = blank;
               cur_row = SCREEN_ROWS - 1;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < SCREEN_CELLS; i++)
               screen_model[i] = blank;
            cur_col = 0;
            cur_row = 0;
         end
         CMD_READ: begin
            if (it.cell_index < SCREEN_CELLS)
               r.cell_data = screen_model[it.cell_index];
         end
         default: ;
      endcase
      r.cursor_pos = loc_type'(cur_row * SCREEN_COLS + cur_col);
      return r;
   endfunction

   task automatic add_req(input cmd_type c, input int b_raw, input int x_raw);
      byte_type b;
      idx_type  x;
      bit       ignored;
      b = byte_type'(b_raw);
      x = idx_type'(x_raw);
      ignored = (c == CMD_SPARE) ||
                (c == CMD_WRITE && b != CH_BS && b != CH_TAB && b != CH_CR &&
                 b != CH_LF && (b < CH_SPACE || b > CH_LAST));
      pending_req.push_back('{cmd: c, char_byte: b, cell_index: x});
      outstanding++;
      if (!ignored) phase_count++;
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsp.push_back(console_step('{cmd: req_ch.cmd,
               char_byte: req_ch.char_byte, cell_index: req_ch.cell_index}));
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (!idle_off && pending_req.size() != 0 &&
                         $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 2);
               req_ch.valid <= 1'b0;
            end else if (pending_req.size() != 0) begin
               next_req = pending_req.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.cmd        <= next_req.cmd;
               req_ch.char_byte  <= next_req.char_byte;
               req_ch.cell_index <= next_req.cell_index;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               got_rsp = expected_rsp.pop_front();
               outstanding--;
               if (rsp_ch.cursor_pos !== got_rsp.cursor_pos) begin
                  $error("cursor_pos mismatch: expected %0d, actual %0d",
                         got_rsp.cursor_pos, rsp_ch.cursor_pos);
                  errors++;
               end
               if (rsp_ch.cell_data !== got_rsp.cell_data) begin
                  $error("cell_data mismatch: expected %h, actual %h",
                         got_rsp.cell_data, rsp_ch.cell_data);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int       ph;
      int       kind;
      int       len;
      int       k;
      int       pick;
      byte_type b;
      attr_type phase_attr;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_WRITE;
      req_ch.char_byte = '0;
      req_ch.cell_index = '0;
      rsp_ch.ready = 1'b0;

      attr_model = RESET_ATTR;
      cur_col = 0;
      cur_row = 0;
      for (k = 0; k < SCREEN_CELLS; k++)
         screen_model[k] = {RESET_ATTR, CH_SPACE};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset attribute
      add_req(CMD_READ, 8'h00, 0);
      add_req(CMD_READ, 8'hFF, IDX_MAX);
      add_req(CMD_READ, 8'h00, SCREEN_CELLS);
      add_req(CMD_READ, 8'h00, SCREEN_CELLS - 1);
      add_req(CMD_WRITE, 8'h41, IDX_MAX);
      add_req(CMD_WRITE, CH_LAST, 0);
      add_req(CMD_WRITE, CH_SPACE, 0);
      add_req(CMD_WRITE, 8'h00, 0);
      add_req(CMD_WRITE, 8'hFF, 0);
      add_req(CMD_WRITE, 8'h80, 0);
      add_req(CMD_WRITE, 8'h1F, 0);
      add_req(CMD_WRITE, CH_BS, 0);
      add_req(CMD_WRITE, CH_TAB, 0);
      add_req(CMD_WRITE, CH_TAB, 0);
      add_req(CMD_WRITE, CH_CR, 0);
      add_req(CMD_WRITE, CH_BS, 0);
      add_req(CMD_WRITE, CH_LF, 0);
      add_req(CMD_READ, 8'h00, 0);
      add_req(CMD_READ, 8'h00, 1);
      add_req(CMD_SPARE, 8'hFF, IDX_MAX);
      add_req(CMD_WRITE, 8'h7E, 0);
      add_req(CMD_CLEAR, 8'hFF, IDX_MAX);
      add_req(CMD_READ, 8'h00, SCREEN_COLS);
      add_req(CMD_READ, 8'h00, 0);

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0:       phase_attr = 8'hFF;
            1:       phase_attr = 8'h00;
            default: phase_attr = attr_type'($urandom_range(1, 254));
         endcase
         if (ph == 3) idle_off = 1'b1;
         @(posedge clock);
         csr_we <= 1'b1;
         csr_wdata <= phase_attr;
         attr_model = phase_attr;
         @(posedge clock);
         csr_we <= 1'b0;

         phase_count = 0;
         while (phase_count < 90) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               // a line of text, now and then long enough to wrap
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90)
                                                 : $urandom_range(0, 12);
               for (k = 0; k < len; k++)
                  add_req(CMD_WRITE, $urandom_range(CH_SPACE, CH_LAST),
                          $urandom_range(0, IDX_MAX));
               pick = $urandom_range(0, 3);
               if (pick == 0) add_req(CMD_WRITE, CH_CR, $urandom_range(0, IDX_MAX));
               if (pick != 3) add_req(CMD_WRITE, CH_LF, $urandom_range(0, IDX_MAX));
            end else if (kind < 55) begin
               len = $urandom_range(1, 6);
               for (k = 0; k < len; k++)
                  add_req(CMD_WRITE, CH_LF, $urandom_range(0, IDX_MAX));
            end else if (kind < 62) begin
               len = $urandom_range(1, 11);
               for (k = 0; k < len; k++)
                  add_req(CMD_WRITE, CH_TAB, $urandom_range(0, IDX_MAX));
            end else if (kind < 68) begin
               len = $urandom_range(1, 10);
               for (k = 0; k < len; k++)
                  add_req(CMD_WRITE, CH_BS, $urandom_range(0, IDX_MAX));
            end else if (kind < 85) begin
               len = $urandom_range(1, 4);
               for (k = 0; k < len; k++) begin
                  pick = $urandom_range(0, 2);
                  add_req(CMD_READ, $urandom_range(0, 255),
                          (pick == 0) ? $urandom_range(0, SCREEN_COLS - 1) :
                          (pick == 1) ? $urandom_range(SCREEN_CELLS - SCREEN_COLS,
                                                       SCREEN_CELLS - 1) :
                                        $urandom_range(0, IDX_MAX));
               end
            end else if (kind < 93) begin
               // bytes the console drops, and the spare command
               if ($urandom_range(0, 1) == 0) begin
                  b = byte_type'($urandom_range(0, CH_SPACE - 1));
                  if (b == CH_BS || b == CH_TAB || b == CH_LF || b == CH_CR)
                     b = b ^ 8'h10;
               end else begin
                  b = byte_type'($urandom_range(8'h80, 8'hFF));
               end
               if ($urandom_range(0, 3) == 0)
                  add_req(CMD_SPARE, $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
               else
                  add_req(CMD_WRITE, b, $urandom_range(0, IDX_MAX));
            end else if (kind < 95) begin
               add_req(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
            end else begin
               add_req(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
            end
         end
      end

      while (outstanding != 0) @(posedge clock);
      repeat (2 * SCREEN_CELLS) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
